>>> src/hsh_pkg.sv
// shared types, constants and the mixing round of the keyed hash block
// no dependencies; imported by every module of the block
package hsh_pkg;

    localparam logic [31:0] IV_LO       = 32'h6c796765;
    localparam logic [31:0] IV_HI       = 32'h74656462;
    localparam logic [31:0] FINAL_TWEAK = 32'h000000ff;
    localparam int unsigned FIN_ROUNDS  = 4;

    typedef logic [3:0][31:0] hsh_state_t;

    typedef enum logic [1:0] {
        KIND_WORD,
        KIND_LAST_FULL,
        KIND_LAST_PART
    } hsh_kind_t;

    typedef struct packed {
        logic [31:0] word;
        logic [7:0]  len;
        logic        first;
        hsh_kind_t   kind;
    } hsh_entry_t;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic hsh_state_t sip_round(input hsh_state_t v_in);
        hsh_state_t v;
        v    = v_in;
        v[0] = v[0] + v[1];
        v[1] = rotl(v[1], 5) ^ v[0];
        v[0] = rotl(v[0], 16);
        v[2] = v[2] + v[3];
        v[3] = rotl(v[3], 8) ^ v[2];
        v[0] = v[0] + v[3];
        v[3] = rotl(v[3], 7) ^ v[0];
        v[2] = v[2] + v[1];
        v[1] = rotl(v[1], 13) ^ v[2];
        v[2] = rotl(v[2], 16);
        return v;
    endfunction

    function automatic hsh_state_t key_state(input logic [63:0] key);
        hsh_state_t v;
        v[0] = key[31:0];
        v[1] = key[63:32];
        v[2] = IV_LO ^ key[31:0];
        v[3] = IV_HI ^ key[63:32];
        return v;
    endfunction

endpackage

>>> src/hsh_front.sv
// input side: accepts message words, tracks message length, classifies words
// depends on hsh_pkg; feeds hsh_queue
module hsh_front import hsh_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_message_word,
    input  logic [2:0]  s_bytes_valid,
    input  logic        s_last,
    input  logic        q_full,
    output logic        q_push,
    output hsh_entry_t  q_entry
);

    logic [7:0] count_reg, count_next;
    logic       open_reg, open_next;
    logic       accept;
    logic [2:0] eff_bytes;
    logic [7:0] len_sum;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign q_push  = accept;

    always_comb begin
        // short counts only matter on the last word
        if (!s_last || s_bytes_valid > 3'd4) begin
            eff_bytes = 3'd4;
        end else begin
            eff_bytes = s_bytes_valid;
        end
        len_sum = (open_reg ? count_reg : 8'd0) + {5'd0, eff_bytes};

        q_entry.len   = len_sum;
        q_entry.first = !open_reg;
        if (!s_last) begin
            q_entry.kind = KIND_WORD;
        end else if (eff_bytes == 3'd4) begin
            q_entry.kind = KIND_LAST_FULL;
        end else begin
            q_entry.kind = KIND_LAST_PART;
        end

        unique case (eff_bytes)
            3'd0:    q_entry.word = 32'd0;
            3'd1:    q_entry.word = {24'd0, s_message_word[7:0]};
            3'd2:    q_entry.word = {16'd0, s_message_word[15:0]};
            3'd3:    q_entry.word = {8'd0, s_message_word[23:0]};
            default: q_entry.word = s_message_word;
        endcase

        count_next = count_reg;
        open_next  = open_reg;
        if (accept) begin
            count_next = s_last ? 8'd0 : len_sum;
            open_next  = !s_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 8'd0;
            open_reg  <= 1'b0;
        end else begin
            count_reg <= count_next;
            open_reg  <= open_next;
        end
    end

endmodule

>>> src/hsh_queue.sv
// short register queue between the input side and the mixing core
// depends on hsh_pkg for the entry type
module hsh_queue import hsh_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  hsh_entry_t push_entry,
    input  logic       pop,
    output hsh_entry_t pop_entry,
    output logic       full,
    output logic       empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    hsh_entry_t       mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push_ok, pop_ok;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign push_ok   = push && !full;
    assign pop_ok    = pop && !empty;
    assign pop_entry = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_ok) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_ok) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_ok && !pop_ok) begin
            count_next = count_reg + 1'b1;
        end else if (pop_ok && !push_ok) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_ok) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");
    a_count_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        (push_ok && !pop_ok) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not follow a push");
    a_full_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue full with pointers apart");
`endif

endmodule

>>> src/hsh_core.sv
// mixing core: one round per cycle unless idle or stalled, absorbs words, finalizes and holds the result
// depends on hsh_pkg; takes classified words from hsh_queue
module hsh_core import hsh_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [63:0] key,
    input  logic        q_valid,
    input  hsh_entry_t  q_entry,
    output logic        q_pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_hash_value
);

    localparam int CNT_W = $clog2(FIN_ROUNDS);
    localparam logic [CNT_W-1:0] FIN_LAST = CNT_W'(FIN_ROUNDS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ABS1,
        ST_ABS2,
        ST_FIN
    } state_t;

    state_t           state_reg, state_next;
    hsh_state_t       v_reg, v_next;
    logic [31:0]      m_reg, m_next;
    logic [31:0]      tail_reg, tail_next;
    logic             tail_pend_reg, tail_pend_next;
    logic             final_reg, final_next;
    logic [CNT_W-1:0] fin_cnt_reg, fin_cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic [31:0]      hash_reg, hash_next;

    hsh_state_t       base, rnd_in, rnd_out;
    logic [31:0]      entry_m;

    assign m_valid      = out_valid_reg;
    assign m_hash_value = hash_reg;

    always_comb begin
        base    = q_entry.first ? key_state(key) : v_reg;
        entry_m = (q_entry.kind == KIND_LAST_PART) ? {q_entry.len, q_entry.word[23:0]}
                                                   : q_entry.word;

        unique case (state_reg)
            ST_IDLE: begin
                rnd_in    = base;
                rnd_in[3] = base[3] ^ entry_m;
            end
            ST_ABS1: begin
                rnd_in    = v_reg;
                rnd_in[3] = v_reg[3] ^ m_reg;
            end
            default: rnd_in = v_reg;
        endcase
        rnd_out = sip_round(rnd_in);

        state_next     = state_reg;
        v_next         = v_reg;
        m_next         = m_reg;
        tail_next      = tail_reg;
        tail_pend_next = tail_pend_reg;
        final_next     = final_reg;
        fin_cnt_next   = fin_cnt_reg;
        hash_next      = hash_reg;
        out_valid_next = out_valid_reg && !m_ready;
        q_pop          = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop          = 1'b1;
                    v_next         = rnd_out;
                    m_next         = entry_m;
                    tail_next      = {q_entry.len, 24'd0};
                    tail_pend_next = (q_entry.kind == KIND_LAST_FULL);
                    final_next     = (q_entry.kind != KIND_WORD);
                    state_next     = ST_ABS2;
                end
            end
            ST_ABS1: begin
                v_next     = rnd_out;
                state_next = ST_ABS2;
            end
            ST_ABS2: begin
                v_next    = rnd_out;
                v_next[0] = rnd_out[0] ^ m_reg;
                if (!final_reg) begin
                    state_next = ST_IDLE;
                end else if (tail_pend_reg) begin
                    m_next         = tail_reg;
                    tail_pend_next = 1'b0;
                    state_next     = ST_ABS1;
                end else begin
                    v_next[2]    = rnd_out[2] ^ FINAL_TWEAK;
                    fin_cnt_next = '0;
                    state_next   = ST_FIN;
                end
            end
            ST_FIN: begin
                if (fin_cnt_reg != FIN_LAST) begin
                    v_next       = rnd_out;
                    fin_cnt_next = fin_cnt_reg + 1'b1;
                end else if (!out_valid_reg || m_ready) begin
                    hash_next      = rnd_out[1] ^ rnd_out[3];
                    out_valid_next = 1'b1;
                    final_next     = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            tail_pend_reg <= 1'b0;
            final_reg     <= 1'b0;
            fin_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            tail_pend_reg <= tail_pend_next;
            final_reg     <= final_next;
            fin_cnt_reg   <= fin_cnt_next;
            out_valid_reg <= out_valid_next;
        end
        v_reg    <= v_next;
        m_reg    <= m_next;
        tail_reg <= tail_next;
        hash_reg <= hash_next;
    end

`ifndef SYNTHESIS
    a_idle_no_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> !tail_pend_reg)
        else $error("tail block left pending in idle");
    a_tail_final: assert property (@(posedge aclk) disable iff (!aresetn)
        tail_pend_reg |-> final_reg)
        else $error("tail pending on a non-final word");
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_FIN)
        else $error("result raised outside finalization");
`endif

endmodule

>>> src/halfsiphash_keyed_hash.sv
// top level of the keyed 32-bit halfsiphash-2-4 block: key register and the
// input side, word queue and mixing core; depends on hsh_pkg, hsh_front,
// hsh_queue and hsh_core
//
// usage:
//  - cfg_*: 64-bit key write, always ready; write it only while the block is idle.
//    bits 31:0 seed state word 0, bits 63:32 state word 1
//  - s_*: message words, little-endian, first byte in bits 7:0. a word with
//    s_last high ends the message and carries 0 to 4 valid bytes; other words
//    always count as four bytes
//  - m_*: one 32-bit hash word per message, after its last word
// timing:
//  - the core runs one mixing round per cycle unless it is idle with no word or
//    held by an untaken result; each word is absorbed in ST_IDLE and ST_ABS2
//  - after the last word, the core runs FIN_ROUNDS finalization rounds in ST_FIN
//    and raises m_valid; a full last word first adds an extra tail block
// reset (aresetn low, synchronous): key zero, no message open, queue empty,
// no result pending
// receiver stall: the hash word is held in the output register; the core keeps
// absorbing the next message and waits only when its next hash is due; when the
// queue fills, s_ready drops
module halfsiphash_keyed_hash import hsh_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    // key write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [63:0] cfg_hash_key,
    // message words
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_message_word,
    input  logic [2:0]  s_bytes_valid,
    input  logic        s_last,
    // hash words
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_hash_value
);

    logic [63:0] key_reg, key_next;

    // classified word path between front and core
    hsh_entry_t  push_entry;
    hsh_entry_t  pop_entry;
    logic        q_push;
    logic        q_pop;
    logic        q_full;
    logic        q_empty;

    // key writes are never refused
    assign cfg_ready = 1'b1;

    always_comb begin
        key_next = key_reg;
        if (cfg_valid && cfg_ready) begin
            key_next = cfg_hash_key;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg <= 64'd0;
        end else begin
            key_reg <= key_next;
        end
    end

    // front: length tracking, tail masking, word kind
    hsh_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_message_word (s_message_word),
        .s_bytes_valid  (s_bytes_valid),
        .s_last         (s_last),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_entry        (push_entry)
    );

    // decouples word intake from the round loop
    hsh_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .pop_entry  (pop_entry),
        .full       (q_full),
        .empty      (q_empty)
    );

    // back: rounds, finalization, output register
    hsh_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .key          (key_reg),
        .q_valid      (!q_empty),
        .q_entry      (pop_entry),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hash_value (m_hash_value)
    );

endmodule
